@@ design/mps_pkg.sv @@
package mps_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned EXP_W  = 31;
	localparam int unsigned DIM_W  = 4;

	typedef enum logic [0:0] {
		REG_DIMENSION = 1'b0,
		REG_EXPONENT  = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_IDENT = 3'd0,
		OP_MUL_AB = 3'd1,
		OP_MUL_BB = 3'd2,
		OP_COPY_A = 3'd3,
		OP_COPY_B = 3'd4
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
	} dp_sts_t;

endpackage

@@ design/mps_datapath.sv @@
module mps_datapath
	import mps_pkg::*;
#(
	parameter int unsigned MAX_DIM = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [$clog2(MAX_DIM+1)-1:0] n,
	input  dp_cmd_t                   cmd,
	output dp_sts_t                   sts,
	input  logic                      ld_we,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] ld_addr,
	input  logic [DATA_W-1:0]         ld_data,
	input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] rd_addr,
	output logic [DATA_W-1:0]         rd_data
);
	localparam int unsigned CELLS = MAX_DIM * MAX_DIM;
	localparam int unsigned IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int unsigned NW = $clog2(MAX_DIM + 1);

	logic [DATA_W-1:0] base_mem [CELLS];
	logic [DATA_W-1:0] acc_mem [CELLS];
	logic [DATA_W-1:0] scr_mem [CELLS];

	logic          busy_q;
	op_t           op_q;
	logic [IW-1:0] i_q, j_q, t_q;
	logic          last_s1, wr_s1, last_s2, wr_s2;
	logic [AW-1:0] dst_s1, dst_s2;
	logic [DATA_W-1:0] a_s1, b_s1, prod_s2, sum_q;
	logic          first_s1, first_s2;

	function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		logic [2*IW:0] w;
		w = {{(IW+1){1'b0}}, r} * (2*IW+1)'(MAX_DIM) + {{(IW+1){1'b0}}, c};
		return w[AW-1:0];
	endfunction

	logic [IW-1:0] nm1;
	assign nm1 = IW'(n - NW'(1));
	logic i_end, j_end, t_end, is_copy, is_id;
	assign is_copy = (op_q == OP_COPY_A) || (op_q == OP_COPY_B);
	assign is_id   = (op_q == OP_IDENT);
	assign t_end = is_copy || is_id || (t_q == nm1);
	assign j_end = (j_q == nm1);
	assign i_end = (i_q == nm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			op_q <= OP_IDENT;
			i_q <= '0; j_q <= '0; t_q <= '0;
			wr_s1 <= 1'b0; wr_s2 <= 1'b0;
			last_s1 <= 1'b0; last_s2 <= 1'b0;
		end else begin
			wr_s1 <= busy_q && t_end;
			last_s1 <= busy_q && t_end && j_end && i_end;
			wr_s2 <= wr_s1;
			last_s2 <= last_s1;
			if (cmd.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q <= cmd.op;
				i_q <= '0; j_q <= '0; t_q <= '0;
			end else if (busy_q) begin
				if (!t_end) t_q <= t_q + IW'(1);
				else begin
					t_q <= '0;
					if (!j_end) j_q <= j_q + IW'(1);
					else begin
						j_q <= '0;
						if (!i_end) i_q <= i_q + IW'(1);
						else busy_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (t_q == '0);
		dst_s1 <= addr(i_q, j_q);
		unique case (op_q)
			OP_IDENT: begin
				a_s1 <= (i_q == j_q) ? DATA_W'(1) : '0;
				b_s1 <= DATA_W'(1);
			end
			OP_MUL_AB: begin
				a_s1 <= acc_mem[addr(i_q, t_q)];
				b_s1 <= base_mem[addr(t_q, j_q)];
			end
			OP_MUL_BB: begin
				a_s1 <= base_mem[addr(i_q, t_q)];
				b_s1 <= base_mem[addr(t_q, j_q)];
			end
			default: begin
				a_s1 <= scr_mem[addr(i_q, j_q)];
				b_s1 <= DATA_W'(1);
			end
		endcase
		prod_s2 <= a_s1 * b_s1;
		first_s2 <= first_s1;
		dst_s2 <= dst_s1;
	end

	logic [DATA_W-1:0] acc_d;
	assign acc_d = (first_s2 ? '0 : sum_q) + prod_s2;

	always_ff @(posedge clk) begin
		sum_q <= acc_d;
		if (wr_s2) begin
			unique case (op_q)
				OP_IDENT, OP_COPY_A: acc_mem[dst_s2] <= acc_d;
				OP_COPY_B: base_mem[dst_s2] <= acc_d;
				default: scr_mem[dst_s2] <= acc_d;
			endcase
		end else if (ld_we) begin
			base_mem[ld_addr] <= ld_data;
		end
		rd_data <= acc_mem[rd_addr];
	end

	assign sts.done = last_s2;

	property p_done_after_busy;
		@(posedge clk) disable iff (!arst_n) last_s2 |-> $past(last_s1);
	endproperty
	a_done: assert property (p_done_after_busy) else $error("done without pipeline");
	a_nostart: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !t_end) |=> busy_q) else $error("busy dropped mid dot product");
	a_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s2 |-> $past(wr_s1)) else $error("write without stage 1");
endmodule

@@ design/mps_ctrl.sv @@
module mps_ctrl
	import mps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       go,
	input  logic [EXP_W-1:0] exp_in,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd,
	output logic       idle,
	output logic       emit
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RUN  = 6'b000010,
		S_WAIT = 6'b000100,
		S_NEXT = 6'b001000,
		S_EMIT = 6'b010000,
		S_HOLD = 6'b100000
	} state_t;

	state_t state_q;
	logic [EXP_W-1:0] e_q;
	op_t op_q;

	assign cmd.start = (state_q == S_RUN);
	assign cmd.op = op_q;
	assign idle = (state_q == S_IDLE);
	assign emit = (state_q == S_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			e_q <= '0;
			op_q <= OP_IDENT;
		end else begin
			unique case (state_q)
				S_IDLE: if (go) begin
					e_q <= exp_in;
					op_q <= OP_IDENT;
					state_q <= S_RUN;
				end
				S_RUN: state_q <= S_WAIT;
				S_WAIT: if (sts.done) state_q <= S_NEXT;
				S_NEXT: begin
					state_q <= S_RUN;
					unique case (op_q)
						OP_IDENT, OP_COPY_B: begin
							if (op_q == OP_COPY_B) e_q <= e_q >> 1;
							if (op_q == OP_COPY_B ? (e_q[EXP_W-1:1] == '0) : (e_q == '0))
								state_q <= S_EMIT;
							else if (op_q == OP_COPY_B ? e_q[1] : e_q[0]) op_q <= OP_MUL_AB;
							else op_q <= OP_MUL_BB;
						end
						OP_MUL_AB: op_q <= OP_COPY_A;
						OP_COPY_A: op_q <= OP_MUL_BB;
						OP_MUL_BB: op_q <= OP_COPY_B;
						default: op_q <= OP_IDENT;
					endcase
				end
				S_EMIT: state_q <= S_HOLD;
				S_HOLD: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_go: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |=> (state_q == S_WAIT)) else $error("run not followed by wait");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |=> (state_q == S_HOLD)) else $error("emit not followed by hold");
	a_wait: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_WAIT) && !sts.done) |=> (state_q == S_WAIT)) else $error("left wait");
endmodule

@@ design/matrix_power_by_squaring.sv @@
// channel | direction | handshake           | payload
// config  | in        | psel/penable/pwrite | paddr, pwdata, prdata
// input   | in        | in_valid/in_ready   | element
// output  | out       | out_valid/out_ready | value, row, col, is_last
// Loading takes one word per cycle while in_ready is high. After the last word the
// identity is built; per exponent bit, when set, the accumulator is multiplied by
// the base and copied, then the base is squared and copied; then n*n words are emitted
// as out_ready allows. Reset clears control state only; matrix stores are undefined
// until written. No new word is taken while a power is computed or results drain.
module matrix_power_by_squaring
	import mps_pkg::*;
#(
	parameter int unsigned MAX_DIM = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [31:0] element,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] value,
	output logic [2:0]  row,
	output logic [2:0]  col,
	output logic        is_last
);
	localparam int unsigned CELLS = MAX_DIM * MAX_DIM;
	localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int unsigned IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int unsigned NW = $clog2(MAX_DIM + 1);

	logic [DIM_W-1:0] dim_q;
	logic [EXP_W-1:0] exp_q;
	logic [NW-1:0] n;
	logic [IW-1:0] lr_q, lc_q, orow_q, ocol_q;
	logic go, idle, emit, wr;
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [DATA_W-1:0] rd_data;
	logic draining_q, pend_q;
	logic [AW-1:0] rd_addr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign n = (dim_q == '0) ? NW'(1) :
		(dim_q > DIM_W'(MAX_DIM)) ? NW'(MAX_DIM) : NW'(dim_q);

	always_comb begin
		unique case (paddr[2])
			REG_DIMENSION: prdata = {28'd0, dim_q};
			default:       prdata = {1'b0, exp_q};
		endcase
	end

	logic [IW-1:0] nm1;
	assign nm1 = IW'(n - NW'(1));
	assign in_ready = idle && !draining_q;
	assign go = in_valid && in_ready && (lr_q == nm1) && (lc_q == nm1);

	function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		logic [2*IW:0] w;
		w = {{(IW+1){1'b0}}, r} * (2*IW+1)'(MAX_DIM) + {{(IW+1){1'b0}}, c};
		return w[AW-1:0];
	endfunction

	logic adv;
	assign adv = draining_q && (!out_valid || out_ready) && !pend_q;
	assign rd_addr = addr(orow_q, ocol_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_W'(1);
			exp_q <= EXP_W'(1);
			lr_q <= '0; lc_q <= '0;
			orow_q <= '0; ocol_q <= '0;
			draining_q <= 1'b0; pend_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (wr && paddr[2] == REG_DIMENSION && paddr[1:0] == 2'b00) begin
				dim_q <= pwdata[DIM_W-1:0];
				lr_q <= '0; lc_q <= '0;
			end
			if (wr && paddr[2] == REG_EXPONENT && paddr[1:0] == 2'b00)
				exp_q <= pwdata[EXP_W-1:0];
			if (in_valid && in_ready) begin
				if (lc_q == nm1) begin
					lc_q <= '0;
					lr_q <= (lr_q == nm1) ? '0 : lr_q + IW'(1);
				end else lc_q <= lc_q + IW'(1);
			end
			if (emit) begin
				draining_q <= 1'b1;
				orow_q <= '0; ocol_q <= '0;
			end
			pend_q <= adv;
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (pend_q) begin
				out_valid <= 1'b1;
				if (is_last) draining_q <= 1'b0;
			end
			if (adv) begin
				if (ocol_q == nm1) begin
					ocol_q <= '0;
					orow_q <= orow_q + IW'(1);
				end else ocol_q <= ocol_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			row <= 3'(orow_q);
			col <= 3'(ocol_q);
			is_last <= (orow_q == nm1) && (ocol_q == nm1);
		end
		if (pend_q) value <= rd_data;
	end

	mps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(go), .exp_in(exp_q),
		.sts(sts), .cmd(cmd), .idle(idle), .emit(emit)
	);

	mps_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
		.clk(clk), .arst_n(arst_n), .n(n), .cmd(cmd), .sts(sts),
		.ld_we(in_valid && in_ready), .ld_addr(addr(lr_q, lc_q)), .ld_data(element),
		.rd_addr(rd_addr), .rd_data(rd_data)
	);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("word dropped");
	a_noin: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> !in_ready) else $error("input during drain");
	a_noover: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (!out_valid || $past(out_ready))) else $error("overwrite");
endmodule
